### hdl/bctt_pkg.sv
// Shared constants, codes and the command type of the blocked corner-turn transpose core.
package bctt_pkg;

   // Default geometry of the band bank.
   localparam int BAND_ROWS_DEF = 32;
   localparam int MAX_COLS_DEF  = 2048;

   // Row count above this limit behaves as the limit itself.
   localparam int ROW_LIMIT = 4096;

   // Configuration register widths and reset values.
   localparam int ROW_COUNT_W = 13;
   localparam int COL_COUNT_W = 12;
   localparam logic [ROW_COUNT_W-1:0] ROW_COUNT_RESET = 13'd64;
   localparam logic [COL_COUNT_W-1:0] COL_COUNT_RESET = 12'd64;

   // Configuration port.
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 13;
   localparam logic [CSR_INDEX_W-1:0] REG_ROW_COUNT = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_COL_COUNT = 1'd1;

   // Item kinds on the request channel.
   localparam logic FUNC_STORE = 1'b0;
   localparam logic FUNC_DRAIN = 1'b1;

   // Payload widths.
   localparam int SAMPLE_W     = 32;
   localparam int ELEM_W       = 2 * SAMPLE_W;
   localparam int OUT_ADDR_W   = 23;
   localparam int REQ_TDATA_W  = 64;
   localparam int REQ_TUSER_W  = 1;
   localparam int RSP_TDATA_W  = 88;
   localparam int RSP_TUSER_W  = 3;

   // Depth of the command queue between front and back.
   localparam int QUEUE_DEPTH = 2;

   // Operations the back end carries out on the bank.
   localparam logic [1:0] OP_NONE  = 2'd0;
   localparam logic [1:0] OP_STORE = 2'd1;
   localparam logic [1:0] OP_LOAD  = 2'd2;

   // One classified word, handed from front to back.
   typedef struct packed {
      logic [1:0]            op;
      logic                  band_last;
      logic                  matrix_last;
      logic                  overrun;
      logic [OUT_ADDR_W-1:0] out_addr;
      logic [ELEM_W-1:0]     data;
   } cmd_type;

endpackage

### hdl/bctt_front.sv
// Front end: classifies request words and keeps the load, drain and band counters.
module bctt_front import bctt_pkg::*; #(
   parameter int  BAND_ROWS = BAND_ROWS_DEF,
   parameter int  MAX_COLS  = MAX_COLS_DEF,
   localparam int MEM_AW    = (MAX_COLS * BAND_ROWS > 1) ? $clog2(MAX_COLS * BAND_ROWS) : 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [ROW_COUNT_W-1:0] row_count,
   input  logic [COL_COUNT_W-1:0] col_count,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   func,
   input  logic [SAMPLE_W-1:0]    sample_re,
   input  logic [SAMPLE_W-1:0]    sample_im,
   output logic                   push_valid,
   input  logic                   push_ready,
   output cmd_type                cmd,
   output logic [MEM_AW-1:0]      cmd_mem_addr
);

   localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int CNT_W  = $clog2(MAX_COLS + 1);
   localparam int ROW_W  = (BAND_ROWS > 1) ? $clog2(BAND_ROWS) : 1;
   localparam int RCNT_W = $clog2(BAND_ROWS + 1);
   localparam int BAND_W = $clog2(ROW_LIMIT / BAND_ROWS + 1);
   localparam int LIM_W  = BAND_W + RCNT_W + 1;

   logic [ROW_W-1:0]  load_row_ff, load_row_in, drain_row_ff, drain_row_in;
   logic [COL_W-1:0]  load_col_ff, load_col_in, drain_col_ff, drain_col_in;
   logic [BAND_W-1:0] band_index_ff, band_index_in;
   logic              band_pending_ff, band_pending_in;

   logic [ROW_COUNT_W-1:0] rows_eff;
   logic [CNT_W-1:0]       cols_eff;
   logic [CNT_W-1:0]       load_col_inc, drain_col_inc;
   logic [RCNT_W-1:0]      load_row_inc, drain_row_inc;
   logic [LIM_W-1:0]       band_limit;
   logic                   bands_zero, band_end, fire;
   logic [OUT_ADDR_W-1:0]  col_term, band_term;

   assign req_ready  = push_ready;
   assign push_valid = req_valid;
   assign fire       = req_valid && push_ready;

   // Effective bounds after clamping the registers.
   assign rows_eff = (row_count > ROW_COUNT_W'(ROW_LIMIT)) ? ROW_COUNT_W'(ROW_LIMIT) : row_count;

   always_comb begin
      if (col_count == '0) begin
         cols_eff = CNT_W'(1);
      end else if ({1'b0, col_count} > (COL_COUNT_W + 1)'(MAX_COLS)) begin
         cols_eff = CNT_W'(MAX_COLS);
      end else begin
         cols_eff = CNT_W'(col_count);
      end
   end

   assign load_col_inc  = CNT_W'(load_col_ff) + CNT_W'(1);
   assign drain_col_inc = CNT_W'(drain_col_ff) + CNT_W'(1);
   assign load_row_inc  = RCNT_W'(load_row_ff) + RCNT_W'(1);
   assign drain_row_inc = RCNT_W'(drain_row_ff) + RCNT_W'(1);

   // The band after this one is beyond the matrix when rows < (band + 2) * band rows.
   assign band_limit = (LIM_W'(band_index_ff) + LIM_W'(2)) * LIM_W'(BAND_ROWS);
   assign band_end   = LIM_W'(rows_eff) < band_limit;
   assign bands_zero = rows_eff < ROW_COUNT_W'(BAND_ROWS);

   assign col_term  = OUT_ADDR_W'(drain_col_ff) * OUT_ADDR_W'(rows_eff);
   assign band_term = OUT_ADDR_W'(band_index_ff) * OUT_ADDR_W'(BAND_ROWS);

   always_comb begin
      load_row_in     = load_row_ff;
      load_col_in     = load_col_ff;
      drain_row_in    = drain_row_ff;
      drain_col_in    = drain_col_ff;
      band_index_in   = band_index_ff;
      band_pending_in = band_pending_ff;
      cmd             = '0;
      cmd_mem_addr    = '0;

      if (func == FUNC_STORE) begin
         if (band_pending_ff) begin
            cmd.overrun = 1'b1;
         end else if (!bands_zero) begin
            cmd.op       = OP_STORE;
            cmd.data     = {sample_re, sample_im};
            cmd_mem_addr = MEM_AW'(load_col_ff) * MEM_AW'(BAND_ROWS) + MEM_AW'(load_row_ff);
            if (load_col_inc >= cols_eff) begin
               load_col_in = '0;
               if (load_row_inc >= RCNT_W'(BAND_ROWS)) begin
                  load_row_in     = '0;
                  band_pending_in = 1'b1;
                  drain_row_in    = '0;
                  drain_col_in    = '0;
               end else begin
                  load_row_in = ROW_W'(load_row_inc);
               end
            end else begin
               load_col_in = COL_W'(load_col_inc);
            end
         end
      end else if (band_pending_ff) begin
         cmd.op       = OP_LOAD;
         cmd.out_addr = col_term + band_term + OUT_ADDR_W'(drain_row_ff);
         cmd_mem_addr = MEM_AW'(drain_col_ff) * MEM_AW'(BAND_ROWS) + MEM_AW'(drain_row_ff);
         if (drain_row_inc >= RCNT_W'(BAND_ROWS)) begin
            drain_row_in = '0;
            if (drain_col_inc >= cols_eff) begin
               drain_col_in    = '0;
               band_pending_in = 1'b0;
               cmd.band_last   = 1'b1;
               if (band_end) begin
                  band_index_in   = '0;
                  cmd.matrix_last = 1'b1;
               end else begin
                  band_index_in = band_index_ff + BAND_W'(1);
               end
            end else begin
               drain_col_in = COL_W'(drain_col_inc);
            end
         end else begin
            drain_row_in = ROW_W'(drain_row_inc);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_row_ff     <= '0;
         load_col_ff     <= '0;
         drain_row_ff    <= '0;
         drain_col_ff    <= '0;
         band_index_ff   <= '0;
         band_pending_ff <= 1'b0;
      end else if (fire) begin
         load_row_ff     <= load_row_in;
         load_col_ff     <= load_col_in;
         drain_row_ff    <= drain_row_in;
         drain_col_ff    <= drain_col_in;
         band_index_ff   <= band_index_in;
         band_pending_ff <= band_pending_in;
      end
   end

   // While a band is held the load position sits at the start of the next band.
   a_load_parked: assert property (@(posedge clock) disable iff (reset)
      band_pending_ff |-> (load_row_ff == '0 && load_col_ff == '0))
      else $error("load position moved while a band was pending");

   // With no band held the drain position is back at the start.
   a_drain_parked: assert property (@(posedge clock) disable iff (reset)
      !band_pending_ff |-> (drain_row_ff == '0 && drain_col_ff == '0))
      else $error("drain position not at start while no band pending");

endmodule

### hdl/bctt_queue.sv
// Short first-in first-out queue of commands between the front and back ends.
module bctt_queue import bctt_pkg::*; #(
   parameter int WIDTH = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   assign push_ready = count_ff != CNT_W'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   // Fill level never exceeds the queue depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("command queue overfilled");

endmodule

### hdl/bctt_back.sv
// Back end: band bank accesses and the registered response word.
module bctt_back import bctt_pkg::*; #(
   parameter int  BAND_ROWS = BAND_ROWS_DEF,
   parameter int  MAX_COLS  = MAX_COLS_DEF,
   localparam int MEM_AW    = (MAX_COLS * BAND_ROWS > 1) ? $clog2(MAX_COLS * BAND_ROWS) : 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  pop_valid,
   output logic                  pop_ready,
   input  cmd_type               cmd,
   input  logic [MEM_AW-1:0]     cmd_mem_addr,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  write_valid,
   output logic [OUT_ADDR_W-1:0] write_address,
   output logic [SAMPLE_W-1:0]   write_re,
   output logic [SAMPLE_W-1:0]   write_im,
   output logic                  band_last,
   output logic                  matrix_last,
   output logic                  overrun
);

   localparam int BANK_DEPTH = MAX_COLS * BAND_ROWS;

   logic [ELEM_W-1:0]     bank_mem [BANK_DEPTH];
   logic [ELEM_W-1:0]     rd_data_ff;
   logic                  rsp_valid_ff;
   logic                  write_valid_ff, band_last_ff, matrix_last_ff, overrun_ff;
   logic [OUT_ADDR_W-1:0] out_addr_ff;
   logic                  advance, pop;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign pop_ready = advance;
   assign pop       = pop_valid && advance;

   // Single-port bank: one write or one read per word.
   always_ff @(posedge clock) begin
      if (pop) begin
         if (cmd.op == OP_STORE) begin
            bank_mem[cmd_mem_addr] <= cmd.data;
         end
         if (cmd.op == OP_LOAD) begin
            rd_data_ff <= bank_mem[cmd_mem_addr];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= pop_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         write_valid_ff <= cmd.op == OP_LOAD;
         out_addr_ff    <= cmd.out_addr;
         band_last_ff   <= cmd.band_last;
         matrix_last_ff <= cmd.matrix_last;
         overrun_ff     <= cmd.overrun;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign write_valid   = write_valid_ff;
   assign write_address = out_addr_ff;
   assign write_re      = write_valid_ff ? rd_data_ff[ELEM_W-1:SAMPLE_W] : '0;
   assign write_im      = write_valid_ff ? rd_data_ff[SAMPLE_W-1:0] : '0;
   assign band_last     = band_last_ff;
   assign matrix_last   = matrix_last_ff;
   assign overrun       = overrun_ff;

   // A dropped sample never carries a write on its response word.
   a_overrun_no_write: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && overrun_ff) |-> !write_valid_ff)
      else $error("overrun word carries a write");

   // Band and matrix marks only ever sit on a write.
   a_marks_on_write: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (band_last_ff || matrix_last_ff)) |-> write_valid_ff)
      else $error("end mark on a word without a write");

endmodule

### hdl/blocked_corner_turn_transpose_core.sv
// Top level of the blocked corner-turn transpose core: configuration registers and wiring.
//
//   Channel  Direction  Handshake             Payload
//   req      in         req_tvalid/tready     tdata: samples, tuser: func
//   rsp      out        rsp_tvalid/tready     tdata: write, tlast: band_last, tuser: flags
//   csr      in         csr_valid/csr_ready   csr_index, csr_data
//
// One word is taken per clock cycle when the response side keeps up; the figure is set by
// the single port of the band bank, which is used once per word (a write for a stored
// sample, a read for a drain). A request word passes through the command queue and then
// the response registers before its response word is presented. Reset clears all counters
// and the command queue; the bank contents stay undefined and no clearing pass runs. A stall
// on the response side fills the two-entry command queue and then holds req_tready low; the
// configuration port is always ready.
module blocked_corner_turn_transpose_core import bctt_pkg::*; #(
   parameter int BAND_ROWS = BAND_ROWS_DEF,
   parameter int MAX_COLS  = MAX_COLS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   // Request channel.
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // sample_re [31:0], sample_im [63:32]
   input  logic [REQ_TUSER_W-1:0] req_tuser,  // func [0]
   // Response channel.
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,  // write_address [22:0], write_re [54:23],
                                              // write_im [86:55], zero [87]
   output logic                   rsp_tlast,  // band_last
   output logic [RSP_TUSER_W-1:0] rsp_tuser,  // write_valid [0], matrix_last [1], overrun [2]
   // Configuration port.
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int MEM_AW = (MAX_COLS * BAND_ROWS > 1) ? $clog2(MAX_COLS * BAND_ROWS) : 1;
   localparam int Q_W    = MEM_AW + $bits(cmd_type);

   logic [ROW_COUNT_W-1:0] row_count_ff;
   logic [COL_COUNT_W-1:0] col_count_ff;

   cmd_type               front_cmd, back_cmd;
   logic [MEM_AW-1:0]     front_mem_addr, back_mem_addr;
   logic                  push_valid, push_ready, pop_valid, pop_ready;
   logic [Q_W-1:0]        pop_data;
   logic                  write_valid, band_last, matrix_last, overrun;
   logic [OUT_ADDR_W-1:0] write_address;
   logic [SAMPLE_W-1:0]   write_re, write_im;

   // Configuration registers. The user must write them only while the core is idle; the block
   // itself does not enforce this. Writes are taken at once.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff <= ROW_COUNT_RESET;
         col_count_ff <= COL_COUNT_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            REG_ROW_COUNT: begin
               row_count_ff <= csr_data[ROW_COUNT_W-1:0];
            end
            REG_COL_COUNT: begin
               col_count_ff <= csr_data[COL_COUNT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // The front end classifies each request word and advances the band counters.
   bctt_front #(
      .BAND_ROWS (BAND_ROWS),
      .MAX_COLS  (MAX_COLS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .row_count    (row_count_ff),
      .col_count    (col_count_ff),
      .req_valid    (req_tvalid),
      .req_ready    (req_tready),
      .func         (req_tuser[0]),
      .sample_re    (req_tdata[SAMPLE_W-1:0]),
      .sample_im    (req_tdata[2*SAMPLE_W-1:SAMPLE_W]),
      .push_valid   (push_valid),
      .push_ready   (push_ready),
      .cmd          (front_cmd),
      .cmd_mem_addr (front_mem_addr)
   );

   // Commands wait here so that a response stall does not freeze the front end at once.
   bctt_queue #(
      .WIDTH (Q_W)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  ({front_mem_addr, front_cmd}),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   assign back_mem_addr = pop_data[Q_W-1:$bits(cmd_type)];
   assign back_cmd      = pop_data[$bits(cmd_type)-1:0];

   // The back end touches the bank and holds the response word.
   bctt_back #(
      .BAND_ROWS (BAND_ROWS),
      .MAX_COLS  (MAX_COLS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .pop_valid     (pop_valid),
      .pop_ready     (pop_ready),
      .cmd           (back_cmd),
      .cmd_mem_addr  (back_mem_addr),
      .rsp_valid     (rsp_tvalid),
      .rsp_ready     (rsp_tready),
      .write_valid   (write_valid),
      .write_address (write_address),
      .write_re      (write_re),
      .write_im      (write_im),
      .band_last     (band_last),
      .matrix_last   (matrix_last),
      .overrun       (overrun)
   );

   assign rsp_tdata = {1'b0, write_im, write_re, write_address};
   assign rsp_tlast = band_last;
   assign rsp_tuser = {overrun, matrix_last, write_valid};

endmodule
